### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, and switched off while rst is high.
`define WTDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define WTDQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/wtdq_pkg.sv
// Shared types, codes and defaults for the wake-time ordered delay queue.
package wtdq_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_TICK_BITS = 32;

  localparam int TASK_W    = 4;
  localparam int NUM_IDS   = 1 << TASK_W;
  localparam int IN_TICK_W = 32;
  localparam int QCOUNT_W  = 5;

  typedef logic [1:0] op_t;
  localparam op_t OP_INSERT   = 2'd0;
  localparam op_t OP_REMOVE   = 2'd1;
  localparam op_t OP_PEEK     = 2'd2;
  localparam op_t OP_CONTAINS = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_ALREADY    = 3'd1;
  localparam status_t ST_NOT_QUEUED = 3'd2;
  localparam status_t ST_AMBIGUOUS  = 3'd3;
  localparam status_t ST_FULL       = 3'd4;

  // Read address source for the entry memory.
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_ZERO = 2'd0;
  localparam rd_sel_t RD_INC  = 2'd1;
  localparam rd_sel_t RD_DEC  = 2'd2;
  localparam rd_sel_t RD_TAIL = 2'd3;

  // Write operation on the entry memory.
  typedef logic [1:0] wr_sel_t;
  localparam wr_sel_t WR_NONE = 2'd0;
  localparam wr_sel_t WR_UP   = 2'd1;
  localparam wr_sel_t WR_DOWN = 2'd2;
  localparam wr_sel_t WR_NEW  = 2'd3;

  typedef struct packed {
    op_t                    op;
    logic [TASK_W-1:0]      task_id;
    logic [IN_TICK_W-1:0]   wake_at;
    logic [IN_TICK_W-1:0]   now;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic                   expired_valid;
    logic [TASK_W-1:0]      expired_task;
    logic                   is_member;
    logic [QCOUNT_W-1:0]    queued_count;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    pos_ld;
    logic    pos_from_ptr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    map_set;
    logic    map_clr;
    logic    status_ld;
    status_t status;
    logic    peek_ld;
    logic    res_ld;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic queued;
    logic full;
    logic empty;
    logic tick_amb;
    logic tick_before;
    logic task_match;
    logic ptr_last;
    logic ptr_at_pos;
    logic res_free;
  } dp_stat_t;

endpackage

### rtl/wake_time_ordered_delay_queue.sv
// Top level of the wake-time ordered delay queue.
//
// Input channel (in_valid, in_ready, in_data) takes one operation per transaction:
// insert, remove, peek at an expired head, or a membership query. Output channel
// (out_valid, out_ready, out_data) returns exactly one result per operation, in order.
// One operation is worked on at a time; in_ready is high only while the block is idle.
// Contains, a peek on an empty queue and an operation rejected at once go straight to
// the result. A peek on a non-empty queue reads the head. An insert scans for its place
// and moves the later entries one place towards the tail before it writes the new
// entry; one rejected for an ambiguous tick stops in the scan. A remove scans for the
// task and moves the later entries one place towards the head.
// The scan and the shift both go through the single read and single write port
// of the entry memory, one entry per cycle. The next operation is taken only
// after the previous result is loaded into the output register.
// A result waits in the output register while the receiver stalls; the block still
// takes the next operation, but holds its result until the register is free.
// Reset empties the queue and clears the output register; it needs no clearing pass.
module wake_time_ordered_delay_queue import wtdq_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int TICK_BITS = DEF_TICK_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wtdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wtdq_dp #(
    .MAX_TASKS (MAX_TASKS),
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/wtdq_dp.sv
// Datapath: entry memory, request and pointer registers, tick compare, result register.
module wtdq_dp import wtdq_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int TICK_BITS = DEF_TICK_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [TICK_BITS-1:0] HALF_RANGE = {1'b1, {(TICK_BITS-1){1'b0}}};

  typedef logic [TICK_BITS-1:0] tick_t;

  logic [TASK_W-1:0] mem_task [MAX_TASKS];
  tick_t             mem_tick [MAX_TASKS];

  op_t               req_op;
  logic [TASK_W-1:0] req_task;
  tick_t             req_tick;
  tick_t             req_now;

  logic [CNT_W-1:0]   count;
  logic [NUM_IDS-1:0] member_map;

  logic [IDX_W-1:0]  ptr;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [TASK_W-1:0] rd_task;
  tick_t             rd_tick;
  logic [TASK_W-1:0] wr_task;
  tick_t             wr_tick;

  status_t           status;
  logic              ev;
  logic [TASK_W-1:0] et;

  logic      res_valid;
  out_item_t res;

  tick_t ins_diff;
  tick_t now_diff;

  assign ins_diff = req_tick - rd_tick;
  assign now_diff = req_now - rd_tick;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_INC:  rd_addr = ptr + 1'b1;
      RD_DEC:  rd_addr = ptr - 1'b1;
      RD_TAIL: rd_addr = IDX_W'(count - 1'b1);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_task = rd_task;
    wr_tick = rd_tick;
    unique case (cmd.wr_sel)
      WR_UP:   wr_addr = ptr + 1'b1;
      WR_DOWN: wr_addr = ptr - 1'b1;
      WR_NEW: begin
        wr_addr = pos;
        wr_task = req_task;
        wr_tick = req_tick;
      end
      default: wr_addr = ptr;
    endcase
  end

  // Entry memory: at most one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_sel != WR_NONE) begin
      mem_task[wr_addr] <= wr_task;
      mem_tick[wr_addr] <= wr_tick;
    end
    if (cmd.rd_en) begin
      rd_task <= mem_task[rd_addr];
      rd_tick <= mem_tick[rd_addr];
      ptr     <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_ld) begin
      pos <= cmd.pos_from_ptr ? ptr : IDX_W'(count);
    end
    if (cmd.load) begin
      req_op   <= in_data.op;
      req_task <= in_data.task_id;
      req_tick <= TICK_BITS'(in_data.wake_at);
      req_now  <= TICK_BITS'(in_data.now);
      status   <= ST_OK;
      ev       <= 1'b0;
      et       <= '0;
    end else begin
      if (cmd.status_ld) begin
        status <= cmd.status;
      end
      if (cmd.peek_ld) begin
        ev <= !now_diff[TICK_BITS-1];
        et <= now_diff[TICK_BITS-1] ? '0 : rd_task;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      member_map <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.map_set) begin
        member_map[req_task] <= 1'b1;
      end else if (cmd.map_clr) begin
        member_map[req_task] <= 1'b0;
      end
    end
  end

  // Output register: a finished result waits here while the next transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_ld) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res.status        <= status;
      res.expired_valid <= ev;
      res.expired_task  <= et;
      res.is_member     <= (req_op == OP_CONTAINS) && member_map[req_task];
      res.queued_count  <= QCOUNT_W'(count);
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res;

  always_comb begin
    stat.op          = req_op;
    stat.queued      = member_map[req_task];
    stat.full        = (count == CNT_W'(MAX_TASKS));
    stat.empty       = (count == '0);
    stat.tick_amb    = (ins_diff == HALF_RANGE);
    stat.tick_before = ins_diff[TICK_BITS-1];
    stat.task_match  = (rd_task == req_task);
    stat.ptr_last    = ((CNT_W'(ptr) + CNT_W'(1)) == count);
    stat.ptr_at_pos  = (ptr == pos);
    stat.res_free    = !res_valid || out_ready;
  end

endmodule

### rtl/wtdq_ctrl.sv
// Controller: sequences decision, scan, shift and result phases of each transaction.
module wtdq_ctrl import wtdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECIDE    = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_SHIFT_INS = 3'd3;
  localparam logic [2:0] S_WRITE_NEW = 3'd4;
  localparam logic [2:0] S_SHIFT_REM = 3'd5;
  localparam logic [2:0] S_PEEK      = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.queued) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_ALREADY;
              state_next    = S_DONE;
            end else if (stat.full) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_FULL;
              state_next    = S_DONE;
            end else if (stat.empty) begin
              cmd.pos_ld = 1'b1;
              state_next = S_WRITE_NEW;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ZERO;
              state_next = S_SCAN;
            end
          end
          OP_REMOVE: begin
            if (!stat.queued) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_NOT_QUEUED;
              state_next    = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ZERO;
              state_next = S_SCAN;
            end
          end
          OP_PEEK: begin
            if (stat.empty) begin
              state_next = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ZERO;
              state_next = S_PEEK;
            end
          end
          OP_CONTAINS: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.op == OP_INSERT) begin
          // Entries past the insertion point are never checked for an ambiguous tick.
          if (stat.tick_amb) begin
            cmd.status_ld = 1'b1;
            cmd.status    = ST_AMBIGUOUS;
            state_next    = S_DONE;
          end else if (stat.tick_before) begin
            cmd.pos_ld       = 1'b1;
            cmd.pos_from_ptr = 1'b1;
            cmd.rd_en        = 1'b1;
            cmd.rd_sel       = RD_TAIL;
            state_next       = S_SHIFT_INS;
          end else if (stat.ptr_last) begin
            cmd.pos_ld = 1'b1;
            state_next = S_WRITE_NEW;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_INC;
          end
        end else begin
          if (stat.task_match) begin
            if (stat.ptr_last) begin
              cmd.cnt_dec = 1'b1;
              cmd.map_clr = 1'b1;
              state_next  = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_INC;
              state_next = S_SHIFT_REM;
            end
          end else if (stat.ptr_last) begin
            cmd.map_clr = 1'b1;
            state_next  = S_DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_INC;
          end
        end
      end
      S_SHIFT_INS: begin
        // Move the entry just read one place towards the tail.
        cmd.wr_sel = WR_UP;
        if (stat.ptr_at_pos) begin
          state_next = S_WRITE_NEW;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_DEC;
        end
      end
      S_WRITE_NEW: begin
        cmd.wr_sel  = WR_NEW;
        cmd.cnt_inc = 1'b1;
        cmd.map_set = 1'b1;
        state_next  = S_DONE;
      end
      S_SHIFT_REM: begin
        cmd.wr_sel = WR_DOWN;
        if (stat.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.map_clr = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_INC;
        end
      end
      S_PEEK: begin
        cmd.peek_ld = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.res_free) begin
          cmd.res_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/wtdq_checker.sv
// Port-level checker for the wake-time ordered delay queue, with its bind statement.
`include "assert_macros.svh"

module wtdq_checker import wtdq_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // After reset the block is idle with no result pending.
  `WTDQ_ASSERT_ALWAYS(a_reset_idle, rst |=> (!out_valid && in_ready), "not idle after reset")

  // A stalled result holds its value.
  `WTDQ_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled result changed")

  // Only one transaction is in work at a time.
  `WTDQ_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "second transaction taken while busy")

  // An expired head is only reported by a successful peek.
  `WTDQ_ASSERT(a_peek_fields, (out_valid && out_data.expired_valid) |-> ((out_data.status == ST_OK) && !out_data.is_member), "peek result fields inconsistent")

  // The reported fill never exceeds the queue depth.
  `WTDQ_ASSERT(a_count_bound, out_valid |-> (int'(out_data.queued_count) <= MAX_TASKS), "queued count above depth")

endmodule

bind wake_time_ordered_delay_queue wtdq_checker #(
  .MAX_TASKS (MAX_TASKS)
) u_wtdq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/tb_wake_time_ordered_delay_queue.sv
// Self-checking testbench for the wake-time ordered delay queue.
module tb_wake_time_ordered_delay_queue;
  import wtdq_pkg::*;

  localparam int SLOTS = DEF_MAX_TASKS;
  localparam int TBITS = DEF_TICK_BITS;
  localparam int RANDOM_ITEMS = 950;
  localparam int PHASE_ITEMS = 50;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_OFF_AFTER = 200;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES = 48;
  localparam int REPORT_MAX = 10;

  localparam int PH_FILL = 0;
  localparam int PH_MIXED = 1;
  localparam int PH_DRAIN = 2;

  localparam int PACE_EAGER = 0;
  localparam int PACE_RANDOM = 1;
  localparam int PACE_SPARSE = 2;

  typedef logic [TBITS-1:0] tick_t;
  typedef logic [TASK_W-1:0] task_t;
  localparam tick_t HALF_TICK = tick_t'(1) << (TBITS - 1);

  // Keeps its own sorted copy of the queue and the results it must produce.
  class delay_queue_scoreboard;
    task_t slot_task[SLOTS];
    tick_t slot_tick[SLOTS];
    int depth;
    logic [NUM_IDS-1:0] queued_map;
    out_item_t expected_q[$];
    int failures;
    int results_seen;

    function new();
      depth = 0;
      queued_map = '0;
      failures = 0;
      results_seen = 0;
    endfunction

    function status_t insert_task(task_t id, tick_t wake);
      int pos;
      tick_t diff;
      if (queued_map[id]) return ST_ALREADY;
      if (depth >= SLOTS) return ST_FULL;
      pos = 0;
      // Only entries up to the insertion point are checked for a half-range gap.
      while (pos < depth) begin
        diff = wake - slot_tick[pos];
        if (diff == HALF_TICK) return ST_AMBIGUOUS;
        if (diff[TBITS-1]) break;
        pos++;
      end
      for (int k = depth; k > pos; k--) begin
        slot_task[k] = slot_task[k-1];
        slot_tick[k] = slot_tick[k-1];
      end
      slot_task[pos] = id;
      slot_tick[pos] = wake;
      depth++;
      queued_map[id] = 1'b1;
      return ST_OK;
    endfunction

    function status_t remove_task(task_t id);
      int pos;
      if (!queued_map[id]) return ST_NOT_QUEUED;
      pos = 0;
      while (pos < depth && slot_task[pos] != id) pos++;
      if (pos < depth) begin
        for (int k = pos; k + 1 < depth; k++) begin
          slot_task[k] = slot_task[k+1];
          slot_tick[k] = slot_tick[k+1];
        end
        depth--;
      end
      queued_map[id] = 1'b0;
      return ST_OK;
    endfunction

    function void note_input(in_item_t item);
      out_item_t res;
      tick_t lag;
      res = '0;
      case (item.op)
        OP_INSERT: res.status = insert_task(item.task_id, tick_t'(item.wake_at));
        OP_REMOVE: res.status = remove_task(item.task_id);
        OP_PEEK: begin
          if (depth > 0) begin
            lag = tick_t'(item.now) - slot_tick[0];
            if (!lag[TBITS-1]) begin
              res.expired_valid = 1'b1;
              res.expired_task = slot_task[0];
            end
          end
        end
        default: res.is_member = queued_map[item.task_id];
      endcase
      res.queued_count = QCOUNT_W'(depth);
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected transaction at %0t: status=%0d ev=%0b et=%0d mem=%0b cnt=%0d",
                   $time, got.status, got.expired_valid, got.expired_task, got.is_member,
                   got.queued_count);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.expired_valid !== want.expired_valid ||
          got.expired_task !== want.expired_task || got.is_member !== want.is_member ||
          got.queued_count !== want.queued_count) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("mismatch at %0t: expected status=%0d ev=%0b et=%0d mem=%0b cnt=%0d",
                   $time, want.status, want.expired_valid, want.expired_task,
                   want.is_member, want.queued_count);
          $display("  got status=%0d ev=%0b et=%0d mem=%0b cnt=%0d",
                   got.status, got.expired_valid, got.expired_task, got.is_member,
                   got.queued_count);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  delay_queue_scoreboard board = new();
  int send_pace = PACE_EAGER;
  int recv_pace = PACE_RANDOM;
  tick_t tick_base = '0;
  int idle_cycles = 0;

  wake_time_ordered_delay_queue dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_wait(int pace);
    case (pace)
      PACE_EAGER: return 0;
      PACE_RANDOM: return $urandom_range(0, 14);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  // Ticks mostly sit close to a moving base, so equal ticks, near misses and
  // half-range gaps all turn up; the rest are fully random.
  function automatic in_item_t make_item(int phase);
    in_item_t item;
    int pick;
    item.task_id = task_t'($urandom_range(0, NUM_IDS - 1));
    item.wake_at = $urandom;
    item.now = $urandom;
    pick = $urandom_range(0, 99);
    case (phase)
      PH_FILL: item.op = (pick < 65) ? OP_INSERT : (pick < 75) ? OP_REMOVE :
                         (pick < 90) ? OP_PEEK : OP_CONTAINS;
      PH_DRAIN: item.op = (pick < 15) ? OP_INSERT : (pick < 65) ? OP_REMOVE :
                          (pick < 85) ? OP_PEEK : OP_CONTAINS;
      default: item.op = (pick < 35) ? OP_INSERT : (pick < 60) ? OP_REMOVE :
                         (pick < 85) ? OP_PEEK : OP_CONTAINS;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 5) item.wake_at = tick_base + $urandom_range(0, 7);
    else if (pick < 7) item.wake_at = tick_base + $urandom_range(0, 200);
    else if (pick < 9) item.wake_at = tick_base + HALF_TICK + $urandom_range(0, 7);
    pick = $urandom_range(0, 9);
    if (pick < 7) item.now = tick_base + $urandom_range(0, 60) - 20;
    else if (pick < 8) item.now = tick_base + HALF_TICK + $urandom_range(0, 7) - 4;
    return item;
  endfunction

  // Holds valid and the payload until the transaction is taken.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = draw_wait(send_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    board.note_input(item);
  endtask

  task automatic issue(input op_t op, input task_t id, input tick_t wake, input tick_t now_tick);
    in_item_t item;
    item.op = op;
    item.task_id = id;
    item.wake_at = wake;
    item.now = now_tick;
    send_item(item);
  endtask

  initial begin : result_sink
    int wait_cycles;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (board.results_seen % 40 == 0) recv_pace = $urandom_range(0, 2);
      wait_cycles = draw_wait(recv_pace);
      // One long stall, so that the queue backs up and in_ready drops.
      if (!held && board.results_seen >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        wait_cycles = HOLD_OFF_CYCLES;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_data);
    end
  end

  initial begin : stimulus
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    issue(OP_PEEK, 4'd0, 32'h0000_0000, 32'h0000_0000);
    issue(OP_CONTAINS, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_REMOVE, 4'd5, 32'h0000_0000, 32'h0000_0000);
    issue(OP_INSERT, 4'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(OP_INSERT, 4'd0, 32'h0000_0007, 32'h0000_0000);
    issue(OP_INSERT, 4'd1, 32'h8000_0000, 32'h0000_0000);
    issue(OP_INSERT, 4'd2, 32'h4000_0000, 32'h0000_0000);
    // Goes to the head; its half-range gap to a later entry is not looked at.
    issue(OP_INSERT, 4'd3, 32'hC000_0000, 32'h0000_0000);
    issue(OP_INSERT, 4'd4, 32'h0000_0000, 32'h0000_0000);
    issue(OP_PEEK, 4'd15, 32'h0000_0000, 32'h3FFF_FFFF);
    issue(OP_PEEK, 4'd0, 32'h0000_0000, 32'h4000_0000);
    issue(OP_PEEK, 4'd0, 32'hFFFF_FFFF, 32'hBFFF_FFFF);
    issue(OP_REMOVE, 4'd3, 32'h0000_0000, 32'h0000_0000);
    issue(OP_PEEK, 4'd0, 32'h0000_0000, 32'h0000_0000);
    issue(OP_CONTAINS, 4'd4, 32'h0000_0000, 32'h0000_0000);
    issue(OP_REMOVE, 4'd0, 32'h0000_0000, 32'h0000_0000);
    issue(OP_PEEK, 4'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(OP_CONTAINS, 4'd0, 32'h0000_0000, 32'h0000_0000);
    issue(OP_INSERT, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_CONTAINS, 4'd15, 32'h0000_0000, 32'h0000_0000);
    issue(OP_REMOVE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_REMOVE, 4'd4, 32'h0000_0000, 32'h0000_0000);
    issue(OP_REMOVE, 4'd2, 32'h0000_0000, 32'h0000_0000);
    issue(OP_PEEK, 4'd0, 32'h0000_0000, 32'h0000_0000);

    tick_base = $urandom;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        send_pace = $urandom_range(0, 2);
        case ($urandom_range(0, 3))
          0: tick_base = $urandom;
          1: tick_base = '1 - tick_t'(8);
          default: ;
        endcase
      end
      phase = (i / PHASE_ITEMS) % 3;
      send_item(make_item(phase));
      tick_base = tick_base + $urandom_range(0, 2);
    end
    in_valid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
